[hw/rtl/ltoi_pkg.sv]
// Types and constants for the line-table opcode interpreter.
// Shared by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ltoi_pkg;

   localparam int LebMaxBytes = 10;
   localparam logic [6:0] LebShiftLimit = 7'(7 * LebMaxBytes);

   localparam logic [2:0] CSR_MIN_INSTR_LENGTH = 3'd0;
   localparam logic [2:0] CSR_DEFAULT_STMT     = 3'd1;
   localparam logic [2:0] CSR_LINE_BASE        = 3'd2;
   localparam logic [2:0] CSR_LINE_RANGE       = 3'd3;
   localparam logic [2:0] CSR_OPCODE_BASE      = 3'd4;

   localparam logic [2:0] KIND_COPY      = 3'd0;
   localparam logic [2:0] KIND_SPECIAL   = 3'd1;
   localparam logic [2:0] KIND_ADV_PC    = 3'd2;
   localparam logic [2:0] KIND_ADV_LINE  = 3'd3;
   localparam logic [2:0] KIND_SET_FILE  = 3'd4;
   localparam logic [2:0] KIND_CONST_ADD = 3'd5;
   localparam logic [2:0] KIND_SET_ADDR  = 3'd6;
   localparam logic [2:0] KIND_END_SEQ   = 3'd7;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_STD   = 2'd1;
   localparam logic [1:0] ERR_EXT   = 2'd2;
   localparam logic [1:0] ERR_TRUNC = 2'd3;

   localparam logic [7:0] OP_EXTENDED    = 8'h00;
   localparam logic [7:0] OP_COPY        = 8'h01;
   localparam logic [7:0] OP_ADVANCE_PC  = 8'h02;
   localparam logic [7:0] OP_ADVANCE_LN  = 8'h03;
   localparam logic [7:0] OP_SET_FILE    = 8'h04;
   localparam logic [7:0] OP_CONST_ADD   = 8'h08;
   localparam logic [7:0] OP_FIRST_SPEC  = 8'h0A;
   localparam logic [7:0] EXT_END_SEQ    = 8'h01;
   localparam logic [7:0] EXT_SET_ADDR   = 8'h02;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_MUL, ST_ADD, ST_EMIT, ST_STUCK
   } state_type;

   typedef enum logic [2:0] {
      PH_FETCH, PH_EXT_LEN, PH_EXT_OP, PH_ADDR, PH_LEB
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [2:0]         op_kind;
      logic [1:0]         error_code;
      logic [63:0]        row_address;
      logic signed [31:0] row_line;
      logic [31:0]        row_file;
      logic               row_is_stmt;
   } rsp_type;

   typedef struct packed {
      logic [7:0]        min_instr_length;
      logic              default_stmt;
      logic signed [7:0] line_adv_min;
      logic [7:0]        line_adv_span;
      logic [7:0]        spec_op_first;
   } cfg_type;

   typedef struct packed {
      logic       accum_clear;
      logic       addr_byte;
      logic       addr_load;
      logic       leb_byte;
      logic       line_leb;
      logic       file_leb;
      logic       div_start;
      logic       adj_const;
      logic       div_step;
      logic       mul_load;
      logic       mul_accum;
      logic       addr_add;
      logic       line_special;
      logic       emit;
      logic       regs_reset;
      logic [2:0] kind;
      logic [1:0] err;
   } cmd_type;

   typedef struct packed {
      logic addr_last;
      logic div_done;
      logic out_busy;
   } sts_type;

endpackage
`default_nettype wire

[hw/rtl/line_table_opcode_interpreter_core.sv]
// Top level of the line-table opcode interpreter: config registers, controller, datapath.
// Depends on ltoi_pkg, ltoi_ctrl and ltoi_dp.
//
//   channel | ports                          | direction | payload
//   req     | req_valid, req_ready, req_data | in        | data_byte, last
//   rsp     | rsp_valid, rsp_ready, rsp_data | out       | op_kind .. row_is_stmt
//   csr     | csr_we, csr_index, csr_wdata   | in        | 8-bit register value
//
// Bytes that finish no instruction stay in the idle state; copy, advance_line, set_file,
// set_address, end of sequence and errors go to emit; advance_pc runs multiply and add,
// and special opcodes and const_add_pc run the bit-serial divide by line range first.
// Reset is synchronous; a result waits in the output register while the rsp side
// stalls, and the next byte is taken as soon as that register has been loaded.
`timescale 1ns / 1ps
`default_nettype none
module line_table_opcode_interpreter_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ltoi_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ltoi_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [7:0]        csr_wdata
);
   ltoi_pkg::cfg_type cfg_ff, cfg_in;
   ltoi_pkg::cmd_type cmd;
   ltoi_pkg::sts_type sts;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ltoi_pkg::CSR_MIN_INSTR_LENGTH: cfg_in.min_instr_length = csr_wdata;
            ltoi_pkg::CSR_DEFAULT_STMT:     cfg_in.default_stmt     = csr_wdata[0];
            ltoi_pkg::CSR_LINE_BASE:        cfg_in.line_adv_min     = csr_wdata;
            ltoi_pkg::CSR_LINE_RANGE:       cfg_in.line_adv_span    = csr_wdata;
            ltoi_pkg::CSR_OPCODE_BASE:      cfg_in.spec_op_first    = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_instr_length <= 8'd1;
         cfg_ff.default_stmt     <= 1'b1;
         cfg_ff.line_adv_min     <= -8'sd5;
         cfg_ff.line_adv_span    <= 8'd14;
         cfg_ff.spec_op_first    <= 8'd13;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ltoi_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .spec_op_first (cfg_ff.spec_op_first),
      .sts           (sts),
      .cmd           (cmd)
   );

   ltoi_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

[hw/rtl/ltoi_ctrl.sv]
// Controller: parse phase and sequencing of the line-program interpreter.
// Depends on ltoi_pkg; drives ltoi_dp through cmd_type and reads sts_type.
`timescale 1ns / 1ps
`default_nettype none
module ltoi_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ltoi_pkg::req_type req_data,
   input  wire logic [7:0]       spec_op_first,
   input  wire ltoi_pkg::sts_type sts,
   output ltoi_pkg::cmd_type     cmd
);
   ltoi_pkg::state_type state_ff, state_in;
   ltoi_pkg::phase_type phase_ff, phase_in;
   logic [2:0] kind_ff, kind_in;
   logic [1:0] err_ff, err_in;
   logic [7:0] pend_ff, pend_in;
   logic [7:0] b;

   assign b = req_data.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ltoi_pkg::ST_IDLE;
         phase_ff <= ltoi_pkg::PH_FETCH;
         kind_ff  <= ltoi_pkg::KIND_COPY;
         err_ff   <= ltoi_pkg::ERR_NONE;
         pend_ff  <= 8'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         err_ff   <= err_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      err_in    = err_ff;
      pend_in   = pend_ff;
      cmd       = '0;
      cmd.kind  = kind_ff;
      cmd.err   = err_ff;
      req_ready = (state_ff == ltoi_pkg::ST_IDLE) || (state_ff == ltoi_pkg::ST_STUCK);
      case (state_ff)
         ltoi_pkg::ST_IDLE: begin
            if (req_valid) begin
               err_in  = ltoi_pkg::ERR_NONE;
               kind_in = ltoi_pkg::KIND_COPY;
               case (phase_ff)
                  ltoi_pkg::PH_FETCH: begin
                     pend_in = b;
                     if (b == ltoi_pkg::OP_EXTENDED) begin
                        cmd.accum_clear = 1'b1;
                        phase_in = ltoi_pkg::PH_EXT_LEN;
                     end else if (b == ltoi_pkg::OP_COPY) begin
                        state_in = ltoi_pkg::ST_EMIT;
                     end else if (b >= ltoi_pkg::OP_ADVANCE_PC && b <= ltoi_pkg::OP_SET_FILE) begin
                        cmd.accum_clear = 1'b1;
                        phase_in = ltoi_pkg::PH_LEB;
                     end else if (b == ltoi_pkg::OP_CONST_ADD) begin
                        cmd.div_start = 1'b1;
                        cmd.adj_const = 1'b1;
                        kind_in  = ltoi_pkg::KIND_CONST_ADD;
                        state_in = ltoi_pkg::ST_DIV;
                     end else if (b >= ltoi_pkg::OP_FIRST_SPEC && b >= spec_op_first) begin
                        cmd.div_start = 1'b1;
                        kind_in  = ltoi_pkg::KIND_SPECIAL;
                        state_in = ltoi_pkg::ST_DIV;
                     end else begin
                        err_in   = ltoi_pkg::ERR_STD;
                        state_in = ltoi_pkg::ST_EMIT;
                     end
                  end
                  ltoi_pkg::PH_EXT_LEN: begin
                     if (!b[7]) phase_in = ltoi_pkg::PH_EXT_OP;
                  end
                  ltoi_pkg::PH_EXT_OP: begin
                     pend_in  = b;
                     phase_in = ltoi_pkg::PH_FETCH;
                     if (b == ltoi_pkg::EXT_END_SEQ) begin
                        kind_in  = ltoi_pkg::KIND_END_SEQ;
                        state_in = ltoi_pkg::ST_EMIT;
                     end else if (b == ltoi_pkg::EXT_SET_ADDR) begin
                        cmd.accum_clear = 1'b1;
                        phase_in = ltoi_pkg::PH_ADDR;
                     end else begin
                        err_in   = ltoi_pkg::ERR_EXT;
                        state_in = ltoi_pkg::ST_EMIT;
                     end
                  end
                  ltoi_pkg::PH_ADDR: begin
                     cmd.addr_byte = 1'b1;
                     if (sts.addr_last) begin
                        cmd.addr_load = 1'b1;
                        kind_in  = ltoi_pkg::KIND_SET_ADDR;
                        state_in = ltoi_pkg::ST_EMIT;
                        phase_in = ltoi_pkg::PH_FETCH;
                     end
                  end
                  ltoi_pkg::PH_LEB: begin
                     cmd.leb_byte = 1'b1;
                     if (!b[7]) begin
                        phase_in = ltoi_pkg::PH_FETCH;
                        if (pend_ff == ltoi_pkg::OP_ADVANCE_PC) begin
                           kind_in  = ltoi_pkg::KIND_ADV_PC;
                           state_in = ltoi_pkg::ST_MUL;
                        end else if (pend_ff == ltoi_pkg::OP_ADVANCE_LN) begin
                           cmd.line_leb = 1'b1;
                           kind_in  = ltoi_pkg::KIND_ADV_LINE;
                           state_in = ltoi_pkg::ST_EMIT;
                        end else begin
                           cmd.file_leb = 1'b1;
                           kind_in  = ltoi_pkg::KIND_SET_FILE;
                           state_in = ltoi_pkg::ST_EMIT;
                        end
                     end
                  end
                  default: phase_in = ltoi_pkg::PH_FETCH;
               endcase
               // data ended inside an instruction
               if (req_data.last && phase_in != ltoi_pkg::PH_FETCH
                   && err_in == ltoi_pkg::ERR_NONE) begin
                  err_in   = ltoi_pkg::ERR_TRUNC;
                  kind_in  = ltoi_pkg::KIND_COPY;
                  state_in = ltoi_pkg::ST_EMIT;
                  phase_in = ltoi_pkg::PH_FETCH;
               end
            end
         end
         ltoi_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ltoi_pkg::ST_MUL;
         end
         ltoi_pkg::ST_MUL: begin
            cmd.mul_load  = 1'b1;
            cmd.mul_accum = (kind_ff == ltoi_pkg::KIND_ADV_PC);
            state_in = ltoi_pkg::ST_ADD;
         end
         ltoi_pkg::ST_ADD: begin
            cmd.addr_add     = 1'b1;
            cmd.line_special = (kind_ff == ltoi_pkg::KIND_SPECIAL);
            state_in = ltoi_pkg::ST_EMIT;
         end
         ltoi_pkg::ST_EMIT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               cmd.regs_reset = (kind_ff == ltoi_pkg::KIND_END_SEQ)
                                && (err_ff == ltoi_pkg::ERR_NONE);
               state_in = (err_ff == ltoi_pkg::ERR_NONE) ? ltoi_pkg::ST_IDLE
                                                          : ltoi_pkg::ST_STUCK;
            end
         end
         ltoi_pkg::ST_STUCK: state_in = ltoi_pkg::ST_STUCK;
         default: state_in = ltoi_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[hw/rtl/ltoi_dp.sv]
// Datapath: operand accumulator, row registers, divider, multiplier, output item.
// Depends on ltoi_pkg; commanded by ltoi_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module ltoi_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ltoi_pkg::req_type  req_data,
   input  wire ltoi_pkg::cfg_type  cfg,
   input  wire ltoi_pkg::cmd_type  cmd,
   output ltoi_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ltoi_pkg::rsp_type      rsp_data
);
   logic [63:0] accum_ff, accum_in;
   logic [6:0]  shift_ff, shift_in;
   logic [63:0] addr_ff, addr_in;
   logic [31:0] line_ff, line_in;
   logic [31:0] file_ff, file_in;
   logic        stmt_ff, stmt_in;
   logic [7:0]  adj_ff, adj_in;
   logic [7:0]  quo_ff, quo_in;
   logic [8:0]  rem_ff, rem_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] prod_ff, prod_in;
   logic        out_valid_ff, out_valid_in;
   ltoi_pkg::rsp_type out_ff, out_in;

   logic [7:0]  b;
   logic [63:0] addr_merge;
   logic        leb_ok;
   logic [6:0]  leb_shift;
   logic [63:0] leb_merge, leb_sext;
   logic [8:0]  rem_sh;
   logic [7:0]  quo_eff, rem_eff;
   logic [63:0] mul_a;

   assign b = req_data.data_byte;

   always_comb begin
      addr_merge = accum_ff | (64'(b) << shift_ff[5:0]);
      leb_ok     = (shift_ff < ltoi_pkg::LebShiftLimit) && (shift_ff < 7'd64);
      leb_merge  = leb_ok ? (accum_ff | (64'(b[6:0]) << shift_ff[5:0])) : accum_ff;
      leb_shift  = leb_ok ? shift_ff + 7'd7 : shift_ff;
      leb_sext   = (leb_shift < 7'd64 && b[6]) ? (leb_merge | ({64{1'b1}} << leb_shift[5:0]))
                                               : leb_merge;
      rem_sh     = {rem_ff[7:0], quo_ff[7]};
      quo_eff    = (cfg.line_adv_span == 8'd0) ? 8'd0 : quo_ff;
      rem_eff    = (cfg.line_adv_span == 8'd0) ? adj_ff : rem_ff[7:0];
      mul_a      = cmd.mul_accum ? accum_ff : 64'(quo_eff);
   end

   always_comb begin
      accum_in = accum_ff;
      shift_in = shift_ff;
      addr_in  = addr_ff;
      line_in  = line_ff;
      file_in  = file_ff;
      stmt_in  = stmt_ff;
      adj_in   = adj_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      out_in   = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (cmd.accum_clear) begin
         accum_in = 64'd0;
         shift_in = 7'd0;
      end
      if (cmd.addr_byte) begin
         accum_in = addr_merge;
         shift_in = shift_ff + 7'd8;
      end
      if (cmd.addr_load) addr_in = addr_merge;
      if (cmd.leb_byte) begin
         accum_in = leb_merge;
         shift_in = leb_shift;
      end
      if (cmd.line_leb) line_in = line_ff + leb_sext[31:0];
      if (cmd.file_leb) file_in = leb_merge[31:0];

      if (cmd.div_start) begin
         adj_in = cmd.adj_const ? ~cfg.spec_op_first : b - cfg.spec_op_first;
         quo_in = cmd.adj_const ? ~cfg.spec_op_first : b - cfg.spec_op_first;
         rem_in = 9'd0;
         cnt_in = 4'd8;
      end else if (cmd.div_step && cnt_ff != 4'd0) begin
         cnt_in = cnt_ff - 4'd1;
         if (rem_sh >= {1'b0, cfg.line_adv_span}) begin
            rem_in = rem_sh - {1'b0, cfg.line_adv_span};
            quo_in = {quo_ff[6:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[6:0], 1'b0};
         end
      end

      if (cmd.mul_load) prod_in = 64'(mul_a * 64'(cfg.min_instr_length));
      if (cmd.addr_add) addr_in = addr_ff + prod_ff;
      if (cmd.line_special)
         line_in = line_ff + {{24{cfg.line_adv_min[7]}}, cfg.line_adv_min} + 32'(rem_eff);

      if (cmd.emit) begin
         out_valid_in       = 1'b1;
         out_in.op_kind     = cmd.kind;
         out_in.error_code  = cmd.err;
         out_in.row_address = addr_ff;
         out_in.row_line    = line_ff;
         out_in.row_file    = file_ff;
         out_in.row_is_stmt = stmt_ff;
      end
      if (cmd.regs_reset) begin
         addr_in = 64'd0;
         line_in = 32'd1;
         file_in = 32'd1;
         stmt_in = cfg.default_stmt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= 64'd0;
         shift_ff     <= 7'd0;
         addr_ff      <= 64'd0;
         line_ff      <= 32'd1;
         file_ff      <= 32'd1;
         stmt_ff      <= 1'b1;
         cnt_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         accum_ff     <= accum_in;
         shift_ff     <= shift_in;
         addr_ff      <= addr_in;
         line_ff      <= line_in;
         file_ff      <= file_in;
         stmt_ff      <= stmt_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      adj_ff  <= adj_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   assign sts.addr_last = (shift_ff == 7'd56);
   assign sts.div_done  = (cnt_ff == 4'd0);
   assign sts.out_busy  = out_valid_ff && !rsp_ready;
   assign rsp_valid     = out_valid_ff;
   assign rsp_data      = out_ff;
endmodule
`default_nettype wire
